// ----- design/sht_pkg.sv -----
package sht_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int POS_EXT_W   = 64;
    localparam int TALLY_DEPTH = 256;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 1'd1;

    localparam logic [11:0] WINDOW_LEN_RESET      = 12'd20;
    localparam logic [7:0]  MATCH_THRESHOLD_RESET = 8'd1;
    localparam logic [7:0]  TALLY_MAX             = 8'd255;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CMD_TBL_RESET = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_HIT       = 3'd3,
        CMD_QUERY     = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        RK_HOLD,
        RK_ZERO,
        RK_APPEND,
        RK_EMPTY,
        RK_TALLY
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FB,
        S_TALLY_RD,
        S_TALLY_UPD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [16:0] last_end;
        logic [7:0]  hits;
    } tally_rec_t;

    typedef struct packed {
        logic      latch_in;
        logic      tbl_reset;
        logic      tally_clear;
        logic      append;
        logic      search_init;
        logic      search_rd;
        logic      search_lo;
        logic      search_hi;
        logic      found_mid;
        logic      fb_rd;
        logic      found_fb;
        logic      seq_from_num;
        logic      tally_rd;
        logic      tally_count;
        res_kind_t res_kind;
        logic      push;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic table_empty;
        logic range_ok;
        logic cmp_lt;
        logic cmp_gt;
        logic next_lt;
        logic mid_last;
        logic mid_zero;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- design/sht_ctrl.sv -----
module sht_ctrl
    import sht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output ctrl_cmd_t  ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.cmd == CMD_HIT) begin
                    state_next = stat.table_empty ? S_DONE : S_SRCH_RD;
                end else if (stat.cmd == CMD_QUERY) begin
                    state_next = S_TALLY_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SRCH_RD: begin
                state_next = stat.range_ok ? S_SRCH_CMP : S_FB;
            end
            S_SRCH_CMP: begin
                if (stat.cmp_lt) begin
                    state_next = (stat.mid_last || stat.next_lt) ? S_TALLY_RD : S_SRCH_RD;
                end else if (stat.cmp_gt) begin
                    state_next = stat.mid_zero ? S_TALLY_RD : S_SRCH_RD;
                end else begin
                    state_next = S_TALLY_RD;
                end
            end
            S_FB:        state_next = S_TALLY_RD;
            S_TALLY_RD:  state_next = S_TALLY_UPD;
            S_TALLY_UPD: state_next = S_DONE;
            S_DONE: begin
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctl          = '0;
        ctl.res_kind = RK_HOLD;
        s_tready     = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                ctl.latch_in = s_tvalid;
            end
            S_DECODE: begin
                unique case (stat.cmd)
                    CMD_TBL_RESET: begin
                        ctl.tbl_reset = 1'b1;
                        ctl.res_kind  = RK_ZERO;
                    end
                    CMD_APPEND: begin
                        ctl.append   = 1'b1;
                        ctl.res_kind = RK_APPEND;
                    end
                    CMD_CLEAR: begin
                        ctl.tally_clear = 1'b1;
                        ctl.res_kind    = RK_ZERO;
                    end
                    CMD_HIT: begin
                        if (stat.table_empty) begin
                            ctl.res_kind = RK_EMPTY;
                        end else begin
                            ctl.search_init = 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        ctl.seq_from_num = 1'b1;
                    end
                    default: begin
                        ctl.res_kind = RK_ZERO;
                    end
                endcase
            end
            S_SRCH_RD: begin
                if (stat.range_ok) begin
                    ctl.search_rd = 1'b1;
                end else begin
                    ctl.fb_rd = 1'b1;
                end
            end
            S_SRCH_CMP: begin
                if (stat.cmp_lt) begin
                    if (stat.mid_last || stat.next_lt) begin
                        ctl.found_mid = 1'b1;
                    end else begin
                        ctl.search_lo = 1'b1;
                    end
                end else if (stat.cmp_gt) begin
                    if (stat.mid_zero) begin
                        ctl.found_mid = 1'b1;
                    end else begin
                        ctl.search_hi = 1'b1;
                    end
                end else begin
                    ctl.found_mid = 1'b1;
                end
            end
            S_FB: begin
                ctl.found_fb = 1'b1;
            end
            S_TALLY_RD: begin
                ctl.tally_rd = 1'b1;
            end
            S_TALLY_UPD: begin
                ctl.tally_count = (stat.cmd == CMD_HIT);
                ctl.res_kind    = RK_TALLY;
            end
            S_DONE: begin
                ctl.push = !stat.out_busy;
            end
            default: begin
                ctl.res_kind = RK_HOLD;
            end
        endcase
    end

endmodule

// ----- design/sht_datapath.sv -----
module sht_datapath
    import sht_pkg::*;
#(
    parameter int MAX_SEQS = 256,
    parameter int POS_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             ctl,
    output dp_status_t            stat,
    input  logic [7:0]            s_tuser,
    input  logic [87:0]           s_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [23:0]           m_tdata
);

    localparam int IDX_W = $clog2(MAX_SEQS);
    localparam int CNT_W = $clog2(MAX_SEQS + 1);

    cmd_t                cmd_reg;
    logic [POS_BITS-1:0] start_reg;
    logic [7:0]          num_reg;
    logic [15:0]         wpos_reg;
    logic [POS_BITS-1:0] hpos_reg;
    logic [POS_EXT_W-1:0] start_ext, hpos_ext;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] low_reg, high_reg, last_reg, mid_reg;
    logic [IDX_W-1:0] mid_next, addr_a, addr_b;
    logic [7:0]       seq_reg;
    logic             table_full;

    logic [POS_BITS-1:0] entry_start_mem [MAX_SEQS];
    logic [7:0]          entry_seq_mem   [MAX_SEQS];
    logic [POS_BITS-1:0] rd_start_a_reg, rd_start_b_reg;
    logic [7:0]          rd_seq_reg;

    tally_rec_t             tally_mem [TALLY_DEPTH];
    logic [TALLY_DEPTH-1:0] tally_valid_reg;
    tally_rec_t             rd_tally_reg, cur_tally, new_tally;
    logic                   rd_tally_valid_reg;
    logic                   counts;
    logic [7:0]             tally_val;

    logic [11:0] wlen_reg;
    logic [7:0]  thr_reg;

    logic [7:0] res_found_reg, res_tally_reg;
    logic       res_passes_reg;
    logic [1:0] res_status_reg;
    logic       m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    assign start_ext = POS_EXT_W'(s_tdata[31:0]);
    assign hpos_ext  = POS_EXT_W'(s_tdata[87:56]);

    always_ff @(posedge aclk) begin
        if (ctl.latch_in) begin
            cmd_reg   <= cmd_t'(s_tuser[2:0]);
            start_reg <= start_ext[POS_BITS-1:0];
            num_reg   <= s_tdata[39:32];
            wpos_reg  <= s_tdata[55:40];
            hpos_reg  <= hpos_ext[POS_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WINDOW_LEN_RESET;
            thr_reg  <= MATCH_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_WINDOW_LEN) begin
                wlen_reg <= cfg_wdata[11:0];
            end else if (cfg_index == REG_MATCH_THRESHOLD) begin
                thr_reg <= cfg_wdata[7:0];
            end
        end
    end

    // table and search pointers
    assign table_full = (count_reg == CNT_W'(MAX_SEQS));
    assign mid_next   = IDX_W'(({1'b0, low_reg} + {1'b0, high_reg}) >> 1);
    assign addr_a     = ctl.fb_rd ? '0 : mid_next;
    assign addr_b     = IDX_W'(mid_next + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.tbl_reset) begin
            count_reg <= '0;
        end else if (ctl.append && !table_full) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.search_init) begin
            low_reg  <= '0;
            high_reg <= IDX_W'(count_reg - 1'b1);
            last_reg <= IDX_W'(count_reg - 1'b1);
        end
        if (ctl.search_rd) begin
            mid_reg <= mid_next;
        end
        if (ctl.search_lo) begin
            low_reg <= IDX_W'(mid_reg + 1'b1);
        end
        if (ctl.search_hi) begin
            high_reg <= IDX_W'(mid_reg - 1'b1);
        end
        if (ctl.found_mid || ctl.found_fb) begin
            seq_reg <= rd_seq_reg;
        end else if (ctl.seq_from_num) begin
            seq_reg <= num_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.append && !table_full) begin
            entry_start_mem[count_reg[IDX_W-1:0]] <= start_reg;
            entry_seq_mem[count_reg[IDX_W-1:0]]   <= num_reg;
        end
        if (ctl.search_rd || ctl.fb_rd) begin
            rd_start_a_reg <= entry_start_mem[addr_a];
            rd_start_b_reg <= entry_start_mem[addr_b];
            rd_seq_reg     <= entry_seq_mem[addr_a];
        end
    end

    // tallies: entries not written since reset or clear read as zero
    assign cur_tally          = rd_tally_valid_reg ? rd_tally_reg : '0;
    assign counts             = ctl.tally_count && (cur_tally.last_end <= {1'b0, wpos_reg});
    assign new_tally.hits     = (cur_tally.hits != TALLY_MAX) ? cur_tally.hits + 1'b1
                                                              : cur_tally.hits;
    assign new_tally.last_end = {1'b0, wpos_reg} + {5'b0, wlen_reg};
    assign tally_val          = counts ? new_tally.hits : cur_tally.hits;

    always_ff @(posedge aclk) begin
        if (ctl.tally_rd) begin
            rd_tally_reg <= tally_mem[seq_reg];
        end
        if (counts) begin
            tally_mem[seq_reg] <= new_tally;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_valid_reg    <= '0;
            rd_tally_valid_reg <= 1'b0;
        end else begin
            if (ctl.tally_clear) begin
                tally_valid_reg <= '0;
            end else if (counts) begin
                tally_valid_reg[seq_reg] <= 1'b1;
            end
            if (ctl.tally_rd) begin
                rd_tally_valid_reg <= tally_valid_reg[seq_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctl.res_kind)
            RK_HOLD: begin
            end
            RK_ZERO: begin
                res_found_reg  <= '0;
                res_tally_reg  <= '0;
                res_passes_reg <= 1'b0;
                res_status_reg <= STAT_OK;
            end
            RK_APPEND: begin
                res_found_reg  <= num_reg;
                res_tally_reg  <= '0;
                res_passes_reg <= 1'b0;
                res_status_reg <= table_full ? STAT_FULL : STAT_OK;
            end
            RK_EMPTY: begin
                res_found_reg  <= '0;
                res_tally_reg  <= '0;
                res_passes_reg <= 1'b0;
                res_status_reg <= STAT_EMPTY;
            end
            RK_TALLY: begin
                res_found_reg  <= seq_reg;
                res_tally_reg  <= tally_val;
                res_passes_reg <= (tally_val >= thr_reg);
                res_status_reg <= STAT_OK;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            m_tdata_reg <= {5'b0, res_status_reg, res_passes_reg, res_tally_reg, res_found_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.cmd         = cmd_reg;
    assign stat.table_empty = (count_reg == '0);
    assign stat.range_ok    = (low_reg <= high_reg);
    assign stat.cmp_lt      = (rd_start_a_reg < hpos_reg);
    assign stat.cmp_gt      = (rd_start_a_reg > hpos_reg);
    assign stat.next_lt     = (hpos_reg < rd_start_b_reg);
    assign stat.mid_last    = (mid_reg >= last_reg);
    assign stat.mid_zero    = (mid_reg == '0);
    assign stat.out_busy    = m_tvalid_reg && !m_tready;

endmodule

// ----- design/seed_hit_tally.sv -----
// channel   direction  tdata (low bit up)                                   tuser
// s_        in         start_pos[31:0] seq_num[39:32] window_pos[55:40]      cmd[2:0]
//                      hit_pos[87:56]
// m_        out        found_seq[7:0] tally[15:8] passes[16] status[18:17]   -
// cfg_      in         index 0 window_len, 1 match_threshold; write when cfg_wr_en
//
// Reset table, append, clear and unused commands go from decode to the result.
// Query reads the tally of seq_num. Hit runs a binary search over the entry memory
// (a registered read, then a compare, per step), falls back to the first entry if
// the search range runs out, then updates the tally; a hit on an empty table reports empty.
// Tally clear works through per-entry valid bits; no clearing pass.
// aresetn empties the table, clears tallies and restores the register defaults.
// A waiting result sits in the output register; the next item is accepted
// meanwhile and its result waits for the register to drain.
module seed_hit_tally
    import sht_pkg::*;
#(
    parameter int MAX_SEQS = 256,
    parameter int POS_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [87:0]           s_tdata,   // start_pos, seq_num, window_pos, hit_pos
    input  logic [7:0]            s_tuser,   // cmd, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // found_seq, tally, passes, status, zero pad
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_cmd_t  ctl;
    dp_status_t stat;

    sht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    sht_datapath #(
        .MAX_SEQS (MAX_SEQS),
        .POS_BITS (POS_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
